@@ hdl/frc8_pkg.sv @@
package frc8_pkg;

    localparam int MaxPayload = 56;
    localparam int AddrW      = $clog2(MaxPayload);
    localparam int LenW       = 6;
    localparam int CfgIdxW    = 2;

    localparam logic [7:0] CrcPoly = 8'h07;
    localparam logic [7:0] CrcInit = 8'h00;

    localparam logic [CfgIdxW-1:0] CfgFirstStart  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSecondStart = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCmdType     = 2'd2;

    typedef enum logic [2:0] {
        ST_SOF1,
        ST_SOF2,
        ST_TYPE,
        ST_LEN,
        ST_DATA,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic crc_init;
        logic load_len;
        logic store_data;
        logic clr_emit;
        logic inc_emit;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sof1_match;
        logic sof2_match;
        logic len_too_big;
        logic len_zero;
        logic data_done;
        logic frame_ok;
        logic emit_last;
        logic out_free;
    } t_sts;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/frc8_ctrl.sv @@
module frc8_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  frc8_pkg::t_sts i_sts,
    output frc8_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);

    frc8_pkg::t_state r_state;
    frc8_pkg::t_state n_state;
    logic             accept;

    assign o_in_stall = (r_state == frc8_pkg::ST_EMIT_RD) || (r_state == frc8_pkg::ST_EMIT_WR);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frc8_pkg::ST_SOF1;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            frc8_pkg::ST_SOF1: begin
                if (accept && i_sts.sof1_match) n_state = frc8_pkg::ST_SOF2;
            end
            frc8_pkg::ST_SOF2: begin
                if (accept) n_state = i_sts.sof2_match ? frc8_pkg::ST_TYPE : frc8_pkg::ST_SOF1;
            end
            frc8_pkg::ST_TYPE: begin
                if (accept) n_state = frc8_pkg::ST_LEN;
            end
            frc8_pkg::ST_LEN: begin
                if (accept) begin
                    if (i_sts.len_too_big) begin
                        n_state = frc8_pkg::ST_SOF1;
                    end else if (i_sts.len_zero) begin
                        n_state = frc8_pkg::ST_CHECK;
                    end else begin
                        n_state = frc8_pkg::ST_DATA;
                    end
                end
            end
            frc8_pkg::ST_DATA: begin
                if (accept && i_sts.data_done) n_state = frc8_pkg::ST_CHECK;
            end
            frc8_pkg::ST_CHECK: begin
                if (accept) n_state = i_sts.frame_ok ? frc8_pkg::ST_EMIT_RD : frc8_pkg::ST_SOF1;
            end
            frc8_pkg::ST_EMIT_RD: begin
                n_state = frc8_pkg::ST_EMIT_WR;
            end
            frc8_pkg::ST_EMIT_WR: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.emit_last ? frc8_pkg::ST_SOF1 : frc8_pkg::ST_EMIT_RD;
                end
            end
            default: n_state = frc8_pkg::ST_SOF1;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            frc8_pkg::ST_TYPE: o_cmd.crc_init = accept;
            frc8_pkg::ST_LEN: o_cmd.load_len = accept && !i_sts.len_too_big;
            frc8_pkg::ST_DATA: o_cmd.store_data = accept;
            frc8_pkg::ST_CHECK: o_cmd.clr_emit = accept;
            frc8_pkg::ST_EMIT_WR: begin
                o_cmd.load_out = i_sts.out_free;
                o_cmd.inc_emit = i_sts.out_free && !i_sts.emit_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hdl/frc8_dpath.sv @@
module frc8_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [frc8_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]                  i_cfg_data,
    input  logic [7:0]                  i_received_byte,
    input  frc8_pkg::t_cmd              i_cmd,
    input  logic                        i_out_stall,
    output frc8_pkg::t_sts              o_sts,
    output logic                        o_out_valid,
    output logic [7:0]                  o_payload_byte,
    output logic [frc8_pkg::LenW-1:0]   o_byte_index,
    output logic [frc8_pkg::LenW-1:0]   o_payload_length,
    output logic                        o_last_byte
);

    logic [7:0] r_first_start;
    logic [7:0] r_second_start;
    logic [7:0] r_cmd_type;

    logic [7:0]                r_frame_type;
    logic [frc8_pkg::LenW-1:0] r_frame_len;
    logic [frc8_pkg::LenW-1:0] r_rx_count;
    logic [7:0]                r_crc;
    logic [frc8_pkg::LenW-1:0] r_emit_idx;
    logic [7:0]                r_rd_data;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic [frc8_pkg::LenW-1:0] r_out_idx;
    logic [frc8_pkg::LenW-1:0] r_out_len;
    logic                      r_out_last;

    logic [7:0] mem [frc8_pkg::MaxPayload];

    logic [7:0]                crc_next;
    logic [frc8_pkg::LenW-1:0] rx_count_inc;
    logic [frc8_pkg::LenW-1:0] emit_idx_inc;

    assign crc_next     = frc8_pkg::crc8_byte(i_cmd.crc_init ? frc8_pkg::CrcInit : r_crc,
                                              i_received_byte);
    assign rx_count_inc = r_rx_count + 1'b1;
    assign emit_idx_inc = r_emit_idx + 1'b1;

    assign o_sts.sof1_match  = (i_received_byte == r_first_start);
    assign o_sts.sof2_match  = (i_received_byte == r_second_start);
    assign o_sts.len_too_big = (i_received_byte > 8'(frc8_pkg::MaxPayload));
    assign o_sts.len_zero    = (i_received_byte == 8'd0);
    assign o_sts.data_done   = (rx_count_inc >= r_frame_len);
    assign o_sts.frame_ok    = (i_received_byte == r_crc) && (r_frame_type == r_cmd_type);
    assign o_sts.emit_last   = (r_frame_len == '0) || (emit_idx_inc == r_frame_len);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_start  <= 8'hAA;
            r_second_start <= 8'h55;
            r_cmd_type     <= 8'h01;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                frc8_pkg::CfgFirstStart:  r_first_start  <= i_cfg_data;
                frc8_pkg::CfgSecondStart: r_second_start <= i_cfg_data;
                frc8_pkg::CfgCmdType:     r_cmd_type     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= '0;
            r_frame_len  <= '0;
            r_rx_count   <= '0;
            r_crc        <= frc8_pkg::CrcInit;
            r_emit_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.crc_init) begin
                r_frame_type <= i_received_byte;
                r_crc        <= crc_next;
            end
            if (i_cmd.load_len) begin
                r_frame_len <= i_received_byte[frc8_pkg::LenW-1:0];
                r_rx_count  <= '0;
                r_crc       <= crc_next;
            end
            if (i_cmd.store_data) begin
                r_rx_count <= rx_count_inc;
                r_crc      <= crc_next;
            end
            if (i_cmd.clr_emit) begin
                r_emit_idx <= '0;
            end else if (i_cmd.inc_emit) begin
                r_emit_idx <= emit_idx_inc;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_data) begin
            mem[r_rx_count[frc8_pkg::AddrW-1:0]] <= i_received_byte;
        end
        r_rd_data <= mem[r_emit_idx[frc8_pkg::AddrW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            // empty frame gives a single zero marker
            r_out_byte <= (r_frame_len == '0) ? 8'd0 : r_rd_data;
            r_out_idx  <= r_emit_idx;
            r_out_len  <= r_frame_len;
            r_out_last <= o_sts.emit_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_byte   = r_out_byte;
    assign o_byte_index     = r_out_idx;
    assign o_payload_length = r_out_len;
    assign o_last_byte      = r_out_last;

endmodule

@@ hdl/frame_receiver_crc8.sv @@
// Byte-serial frame receiver with CRC-8 check (poly 0x07, init 0, MSB first).
// Input channel: i_received_byte with i_in_valid / o_in_stall; one serial byte
// per request. The block hunts for two start bytes, then takes type, length,
// payload and one check byte.
// Output channel: o_payload_byte, o_byte_index, o_payload_length, o_last_byte
// with o_out_valid / i_out_stall; one request per payload byte of a good
// command frame, the last one flagged. An empty good frame gives one zero
// marker request. Frames with bad CRC, other type or too long a length are
// dropped without output.
// Throughput: one input byte per cycle while receiving. After a good check
// byte the input stalls while the payload store is read out: each payload
// byte (or the marker of an empty frame) goes through a registered memory
// read, then an output register load. The readout also waits while the
// receiver stalls the output. The first payload byte shows once the check
// byte is taken and its memory read and output register load have followed.
// Reset (synchronous, active low) returns to start-byte hunt, clears the
// output valid and restores the start bytes 0xAA, 0x55 and command type 0x01.
// A stalled output holds its request; the readout waits until it is taken.
module frame_receiver_crc8 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [frc8_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]                  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_received_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_payload_byte,
    output logic [frc8_pkg::LenW-1:0]   o_byte_index,
    output logic [frc8_pkg::LenW-1:0]   o_payload_length,
    output logic                        o_last_byte
);

    frc8_pkg::t_cmd cmd;
    frc8_pkg::t_sts sts;

    frc8_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    frc8_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_received_byte  (i_received_byte),
        .i_cmd            (cmd),
        .i_out_stall      (i_out_stall),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_payload_length (o_payload_length),
        .o_last_byte      (o_last_byte)
    );

endmodule

@@ hdl/frc8_checker.sv @@
module frc8_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [7:0]                o_payload_byte,
    input logic [frc8_pkg::LenW-1:0] o_byte_index,
    input logic [frc8_pkg::LenW-1:0] o_payload_length,
    input logic                      o_last_byte
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output request dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_payload_byte) && $stable(o_byte_index) &&
            $stable(o_payload_length) && $stable(o_last_byte))
        else $error("output payload changed while stalled");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_byte |->
            ({1'b0, o_byte_index} + 7'd1) < {1'b0, o_payload_length})
        else $error("non-final byte index beyond frame length");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |->
            (o_payload_length == '0 && o_byte_index == '0 && o_payload_byte == 8'd0) ||
            (({1'b0, o_byte_index} + 7'd1) == {1'b0, o_payload_length}))
        else $error("final flag on wrong byte");

endmodule

bind frame_receiver_crc8 frc8_checker u_frc8_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_payload_byte   (o_payload_byte),
    .o_byte_index     (o_byte_index),
    .o_payload_length (o_payload_length),
    .o_last_byte      (o_last_byte)
);

@@ dv/frame_receiver_crc8_test.sv @@
module frame_receiver_crc8_test;

    localparam logic [7:0] Sof1Rst = 8'hAA;
    localparam logic [7:0] Sof2Rst = 8'h55;
    localparam logic [7:0] CmdRst  = 8'h01;
    localparam logic [frc8_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic [7:0]                data;
        logic [frc8_pkg::LenW-1:0] idx;
        logic [frc8_pkg::LenW-1:0] len;
        logic                      last;
    } t_payload_res;

    typedef enum {FILL_INC, FILL_ZERO, FILL_ONES, FILL_RAND} t_fill;
    // CHK_MODEL: predictor decides; others are typed-in expectations
    typedef enum {CHK_MODEL, CHK_NONE, CHK_MARKER} t_chk;

    typedef struct {
        logic       has_lead;
        logic [7:0] lead;
        logic [7:0] sof_a;
        logic [7:0] sof_b;
        logic [7:0] ftype;
        logic [7:0] flen;
        t_fill      fill;
        logic [7:0] crc_xor;
        int         cut;
        t_chk       chk;
    } t_frame_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [frc8_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic [7:0]                    i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [7:0]                    i_received_byte;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [7:0]                    o_payload_byte;
    logic [frc8_pkg::LenW-1:0]     o_byte_index;
    logic [frc8_pkg::LenW-1:0]     o_payload_length;
    logic                          o_last_byte;

    frame_receiver_crc8 dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_received_byte  (i_received_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_payload_length (o_payload_length),
        .o_last_byte      (o_last_byte)
    );

    // predictor state and register copy
    logic [7:0]                cfg_sof1;
    logic [7:0]                cfg_sof2;
    logic [7:0]                cfg_cmd;
    frc8_pkg::t_state          rx_ph;
    logic [7:0]                rx_type;
    logic [frc8_pkg::LenW-1:0] rx_len;
    int                        rx_cnt;
    logic [7:0]                rx_crc;
    logic [7:0]                rx_store [frc8_pkg::MaxPayload];

    t_payload_res    deframed [$];
    t_payload_res    payload_due [$];
    logic [7:0]      tx_bytes [$];
    t_frame_row      dir_rows [17];

    bit              hold_model = 1'b0;
    int              burst_left = 0;
    int              mismatches = 0;
    int              stall_win = 0;
    logic [15:0]     stall_pat;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // serial form of CRC-8: feed data bits MSB first through the LFSR
    function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ d[k];
            r = {r[6:0], 1'b0} ^ (fb ? frc8_pkg::CrcPoly : 8'h00);
        end
        return r;
    endfunction

    function void deframer_reset();
        cfg_sof1 = Sof1Rst;
        cfg_sof2 = Sof2Rst;
        cfg_cmd  = CmdRst;
        rx_ph    = frc8_pkg::ST_SOF1;
        rx_type  = 8'h00;
        rx_len   = '0;
        rx_cnt   = 0;
        rx_crc   = 8'h00;
    endfunction

    function void deframe_byte(input logic [7:0] b);
        t_payload_res r;
        case (rx_ph)
            frc8_pkg::ST_SOF1: begin
                if (b == cfg_sof1) rx_ph = frc8_pkg::ST_SOF2;
            end
            frc8_pkg::ST_SOF2: begin
                // a wrong second byte is dropped, not retried as a first byte
                rx_ph = (b == cfg_sof2) ? frc8_pkg::ST_TYPE : frc8_pkg::ST_SOF1;
            end
            frc8_pkg::ST_TYPE: begin
                rx_type = b;
                rx_crc = crc8_next(8'h00, b);
                rx_ph = frc8_pkg::ST_LEN;
            end
            frc8_pkg::ST_LEN: begin
                if (b > frc8_pkg::MaxPayload) begin
                    rx_ph = frc8_pkg::ST_SOF1;
                end else begin
                    rx_len = b[frc8_pkg::LenW-1:0];
                    rx_cnt = 0;
                    rx_crc = crc8_next(rx_crc, b);
                    rx_ph = (b == 8'h00) ? frc8_pkg::ST_CHECK : frc8_pkg::ST_DATA;
                end
            end
            frc8_pkg::ST_DATA: begin
                rx_store[rx_cnt] = b;
                rx_crc = crc8_next(rx_crc, b);
                rx_cnt++;
                if (rx_cnt >= rx_len) rx_ph = frc8_pkg::ST_CHECK;
            end
            frc8_pkg::ST_CHECK: begin
                if (b == rx_crc && rx_type == cfg_cmd) begin
                    if (rx_len == 0) begin
                        r = '{8'h00, 6'd0, 6'd0, 1'b1};
                        deframed.push_back(r);
                    end else begin
                        for (int i = 0; i < rx_len; i++) begin
                            r = '{rx_store[i], 6'(i), rx_len, (i + 1 == rx_len)};
                            deframed.push_back(r);
                        end
                    end
                end
                rx_ph = frc8_pkg::ST_SOF1;
            end
            default: rx_ph = frc8_pkg::ST_SOF1;
        endcase
    endfunction

    function void build_frame(input t_frame_row fr);
        logic [7:0] crc;
        logic [7:0] d;
        tx_bytes.delete();
        if (fr.has_lead) tx_bytes.push_back(fr.lead);
        tx_bytes.push_back(fr.sof_a);
        tx_bytes.push_back(fr.sof_b);
        tx_bytes.push_back(fr.ftype);
        tx_bytes.push_back(fr.flen);
        // oversize length: header only, the block drops it there
        if (fr.flen <= frc8_pkg::MaxPayload) begin
            crc = crc8_next(crc8_next(8'h00, fr.ftype), fr.flen);
            for (int i = 0; i < fr.flen; i++) begin
                case (fr.fill)
                    FILL_INC:  d = 8'(i);
                    FILL_ZERO: d = 8'h00;
                    FILL_ONES: d = 8'hFF;
                    default:   d = 8'($urandom);
                endcase
                crc = crc8_next(crc, d);
                tx_bytes.push_back(d);
            end
            tx_bytes.push_back(crc ^ fr.crc_xor);
        end
        if (fr.cut > 0) begin
            while (tx_bytes.size() > fr.cut) void'(tx_bytes.pop_back());
        end
    endfunction

    task put_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_received_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        deframe_byte(b);
        if (!hold_model) begin
            foreach (deframed[k]) payload_due.push_back(deframed[k]);
        end
        deframed.delete();
    endtask

    task send_frame();
        foreach (tx_bytes[k]) put_byte(tx_bytes[k]);
    endtask

    // drop the last request, wait until every payload request is out,
    // then let the readout settle
    task settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (payload_due.size() != 0) @(posedge i_clk);
        repeat (12) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task set_reg(input logic [frc8_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            frc8_pkg::CfgFirstStart:  cfg_sof1 = val;
            frc8_pkg::CfgSecondStart: cfg_sof2 = val;
            frc8_pkg::CfgCmdType:     cfg_cmd = val;
            default: ;
        endcase
    endtask

    task random_frame();
        t_frame_row fr;
        int         pick;
        fr.has_lead = ($urandom_range(0, 9) == 0);
        fr.lead = 8'($urandom);
        fr.sof_a = cfg_sof1;
        fr.sof_b = ($urandom_range(0, 19) == 0) ? 8'($urandom) : cfg_sof2;
        fr.ftype = ($urandom_range(0, 9) < 8) ? cfg_cmd : 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) fr.flen = 8'($urandom_range(0, 8));
        else if (pick < 88) fr.flen = 8'($urandom_range(9, frc8_pkg::MaxPayload - 1));
        else if (pick < 94) fr.flen = 8'(frc8_pkg::MaxPayload);
        else fr.flen = 8'($urandom_range(frc8_pkg::MaxPayload + 1, 255));
        fr.fill = FILL_RAND;
        fr.crc_xor = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        fr.cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 8) : 0;
        fr.chk = CHK_MODEL;
        build_frame(fr);
        send_frame();
    endtask

    task run_phase(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] ct,
                   input int n_bytes);
        int sent;
        settle();
        set_reg(frc8_pkg::CfgFirstStart, s1);
        set_reg(frc8_pkg::CfgSecondStart, s2);
        set_reg(frc8_pkg::CfgCmdType, ct);
        sent = 0;
        while (sent < n_bytes) begin
            random_frame();
            sent += tx_bytes.size();
        end
    endtask

    // receiver stall pattern, reshuffled whenever its random window runs out
    always @(negedge i_clk) begin
        if (stall_win == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = 16'h0000;
                1: stall_pat = 16'($urandom);
                2: stall_pat = 16'($urandom & $urandom);
                default: stall_pat = 16'($urandom | $urandom);
            endcase
            stall_win = $urandom_range(16, 80);
        end
        stall_win--;
        i_out_stall <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
    end

    function void field_check(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : payload_mon
        t_payload_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (payload_due.size() == 0) begin
                $display("%0t: unexpected request expected none actual %0d/%0d/%0d/%0d",
                         $time, o_payload_byte, o_byte_index, o_payload_length,
                         o_last_byte);
                mismatches++;
            end else begin
                want = payload_due.pop_front();
                field_check("payload_byte", want.data, o_payload_byte);
                field_check("byte_index", want.idx, o_byte_index);
                field_check("payload_length", want.len, o_payload_length);
                field_check("last_byte", want.last, o_last_byte);
            end
        end
    end

    initial begin : watchdog
        repeat (CycleLimit) @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = frc8_pkg::CfgFirstStart;
        i_cfg_data = 8'h00;
        i_in_valid = 1'b0;
        i_received_byte = 8'h00;
        i_out_stall = 1'b0;
        deframer_reset();

        dir_rows = '{
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd1, FILL_ZERO, 8'h00, 0, CHK_MODEL},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd1, FILL_ONES, 8'h00, 0, CHK_MODEL},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd0, FILL_INC, 8'h00, 0, CHK_MARKER},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd56, FILL_INC, 8'h00, 0, CHK_MODEL},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd56, FILL_ONES, 8'h00, 0, CHK_MODEL},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd3, FILL_RAND, 8'h00, 0, CHK_MODEL},
            // oversize lengths
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd57, FILL_INC, 8'h00, 0, CHK_NONE},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'hFF, FILL_INC, 8'h00, 0, CHK_NONE},
            // bad check byte
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd2, FILL_INC, 8'h01, 0, CHK_NONE},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd0, FILL_INC, 8'h80, 0, CHK_NONE},
            // other frame types
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, 8'h02, 8'd2, FILL_INC, 8'h00, 0, CHK_NONE},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, 8'hFF, 8'd0, FILL_INC, 8'h00, 0, CHK_NONE},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, 8'h00, 8'd1, FILL_ONES, 8'h00, 0, CHK_NONE},
            // wrong second start byte
            '{1'b0, 8'h00, Sof1Rst, 8'h54, CmdRst, 8'd1, FILL_INC, 8'h00, 2, CHK_NONE},
            // first byte repeated: the repeat must not count as a new first byte
            '{1'b1, Sof1Rst, Sof1Rst, Sof2Rst, CmdRst, 8'd0, FILL_INC, 8'h00, 0, CHK_NONE},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd2, FILL_INC, 8'h00, 0, CHK_MODEL},
            '{1'b0, 8'h00, Sof1Rst, Sof2Rst, CmdRst, 8'd7, FILL_RAND, 8'h00, 0, CHK_MODEL}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            build_frame(dir_rows[n]);
            hold_model = (dir_rows[n].chk != CHK_MODEL);
            send_frame();
            if (dir_rows[n].chk == CHK_MARKER) payload_due.push_back('{8'h00, 6'd0, 6'd0, 1'b1});
            hold_model = 1'b0;
        end

        run_phase(8'h00, 8'hFF, 8'h00, 8);
        run_phase(8'hFF, 8'h00, 8'hFF, 8);
        run_phase(8'h7E, 8'h7E, 8'($urandom), 8);
        settle();
        set_reg(CfgUnused, 8'($urandom));
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8);
        run_phase(Sof1Rst, Sof2Rst, CmdRst, 8);

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
